/* sv/zvn_pkg.sv */
// ----------------------------------------------------------------------------
// zvn_pkg
// Shared types and constants for the z-score vector normalizer.
// ----------------------------------------------------------------------------
package zvn_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int OUT_WIDTH    = 16;
    localparam int FRAC_BITS    = 10;
    localparam int Q_BITS       = 14;
    localparam int QB_W         = 4;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_WIDTH-1:0] normalized;
        logic                        last_out;
        logic                        dropped;
    } t_out_item;

    typedef enum logic [3:0] {
        S_LOAD,
        S_SQ_RD,
        S_SQ_D,
        S_SQ_MUL,
        S_SQ_ACC,
        S_Z_RD,
        S_Z_D,
        S_Z_MUL,
        S_Z_R,
        S_Z_INIT,
        S_Z_CAND,
        S_Z_CMP,
        S_Z_FIN,
        S_Z_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic calc_d;
        logic calc_sq;
        logic acc_d2;
        logic calc_r;
        logic z_init;
        logic z_cand;
        logic z_cmp;
        logic z_fin;
        logic idx_clr;
        logic idx_inc;
        logic clr_vec;
    } t_cmd;

    typedef struct packed {
        logic last_elem;
        logic bit_done;
    } t_stat;

endpackage

/* sv/zscore_vector_normalizer.sv */
// ----------------------------------------------------------------------------
// zscore_vector_normalizer
// Buffers a Q8.8 vector and emits each element as a Q5.10 z-score.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid/o_in_ready, i_in_data): one sample per transfer;
// is_last closes the vector. Samples past MAX_SAMPLES are dropped and flag
// every result of that vector. Ready is high only while loading.
// After the last transfer, a deviation pass reads each stored element,
// then each result goes through read, deviation, square, scale, and 14
// steps of a bitwise magnitude search, each step one wide shift-add and
// one compare.
// Output channel (o_out_valid/i_out_ready, o_out_data): results in load
// order, last_out on the final one. A stalled result holds in the output
// register; the sequencer waits and no new sample is taken until the
// vector is fully delivered. Reset empties the vector and returns to load.
// ----------------------------------------------------------------------------
module zscore_vector_normalizer
    import zvn_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    zvn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_last   (i_in_data.is_last),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    zvn_dp #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_data  (i_in_data),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

/* sv/zvn_ram.sv */
// ----------------------------------------------------------------------------
// zvn_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module zvn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/zvn_ctrl.sv */
// ----------------------------------------------------------------------------
// zvn_ctrl
// Sequencer: load, squared-deviation pass, per-element z-score iteration.
// ----------------------------------------------------------------------------
module zvn_ctrl
    import zvn_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_last,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_out_valid
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:   if (i_in_valid && i_in_last) n_state = S_SQ_RD;
            S_SQ_RD:  n_state = S_SQ_D;
            S_SQ_D:   n_state = S_SQ_MUL;
            S_SQ_MUL: n_state = S_SQ_ACC;
            S_SQ_ACC: n_state = i_stat.last_elem ? S_Z_RD : S_SQ_RD;
            S_Z_RD:   n_state = S_Z_D;
            S_Z_D:    n_state = S_Z_MUL;
            S_Z_MUL:  n_state = S_Z_R;
            S_Z_R:    n_state = S_Z_INIT;
            S_Z_INIT: n_state = S_Z_CAND;
            S_Z_CAND: n_state = S_Z_CMP;
            S_Z_CMP:  n_state = i_stat.bit_done ? S_Z_FIN : S_Z_CAND;
            S_Z_FIN:  n_state = S_Z_OUT;
            S_Z_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.last_elem ? S_LOAD : S_Z_RD;
                end
            end
            default:  n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid;
                o_cmd.start   = i_in_valid && i_in_last;
                o_cmd.idx_clr = i_in_valid && i_in_last;
            end
            S_SQ_D:   o_cmd.calc_d  = 1'b1;
            S_SQ_MUL: o_cmd.calc_sq = 1'b1;
            S_SQ_ACC: begin
                o_cmd.acc_d2  = 1'b1;
                o_cmd.idx_clr = i_stat.last_elem;
                o_cmd.idx_inc = !i_stat.last_elem;
            end
            S_Z_D:    o_cmd.calc_d  = 1'b1;
            S_Z_MUL:  o_cmd.calc_sq = 1'b1;
            S_Z_R:    o_cmd.calc_r  = 1'b1;
            S_Z_INIT: o_cmd.z_init  = 1'b1;
            S_Z_CAND: o_cmd.z_cand  = 1'b1;
            S_Z_CMP:  o_cmd.z_cmp   = 1'b1;
            S_Z_FIN:  o_cmd.z_fin   = 1'b1;
            S_Z_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.clr_vec = i_out_ready && i_stat.last_elem;
                o_cmd.idx_inc = i_out_ready && !i_stat.last_elem;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* sv/zvn_dp.sv */
// ----------------------------------------------------------------------------
// zvn_dp
// Datapath: sample buffer, sums, deviation square and bitwise z magnitude.
// ----------------------------------------------------------------------------
module zvn_dp
    import zvn_pkg::*;
#(
    parameter int MAX_SAMPLES = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in_data,
    output t_stat     o_stat,
    output t_out_item o_out_data
);

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SUMW = SAMPLE_WIDTH + CW;
    localparam int DW   = SUMW + 1;
    localparam int DMW  = DW - 1;
    localparam int SQW  = 2 * DMW;
    localparam int D2W  = SQW + CW;
    localparam int RW   = SQW + CW + 2 * FRAC_BITS + 2;
    localparam int XW   = D2W + 2 * Q_BITS + 2;

    logic [CW-1:0]               r_count;
    logic signed [SUMW-1:0]      r_sum;
    logic                        r_ovf;
    logic [CW-1:0]               r_idx;
    logic signed [DW-1:0]        r_d;
    logic                        r_dneg;
    logic                        r_dzero;
    logic [SQW-1:0]              r_sq;
    logic [D2W-1:0]              r_d2;
    logic [RW-1:0]               r_r;
    logic [XW-1:0]               r_a;
    logic signed [XW:0]          r_b;
    logic signed [XW:0]          r_cand;
    logic [Q_BITS-1:0]           r_q;
    logic [QB_W-1:0]             r_bit;
    t_out_item                   r_out;

    logic                        w_room;
    logic [SAMPLE_WIDTH-1:0]     w_rdata;
    logic signed [DW-1:0]        w_n_s;
    logic signed [DW-1:0]        w_s_s;
    logic signed [DW-1:0]        w_prod;
    logic signed [DW-1:0]        w_sum_s;
    logic signed [DW-1:0]        w_dabs;
    logic [SQW-1:0]              w_dmag;
    logic [XW-1:0]               w_d2x;
    logic signed [XW:0]          w_rx;
    logic [OUT_WIDTH-1:0]        w_mag;

    assign w_room  = r_count < CW'(MAX_SAMPLES);
    assign w_n_s   = $signed({{(DW-CW){1'b0}}, r_count});
    assign w_s_s   = $signed({{(DW-SAMPLE_WIDTH){w_rdata[SAMPLE_WIDTH-1]}}, w_rdata});
    assign w_prod  = w_n_s * w_s_s;
    assign w_sum_s = $signed({{(DW-SUMW){r_sum[SUMW-1]}}, r_sum});
    assign w_dabs  = r_d[DW-1] ? -r_d : r_d;
    assign w_dmag  = SQW'(w_dabs[DMW-1:0]);
    assign w_d2x   = XW'(r_d2);
    assign w_rx    = $signed({1'b0, XW'(r_r)});
    assign w_mag   = OUT_WIDTH'(r_q);

    zvn_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_SAMPLES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_room),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_in_data.sample),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_ovf   <= 1'b0;
            r_idx   <= '0;
            r_bit   <= '0;
        end else begin
            if (i_cmd.clr_vec) begin
                r_count <= '0;
                r_sum   <= '0;
                r_ovf   <= 1'b0;
            end else if (i_cmd.load) begin
                if (w_room) begin
                    r_count <= r_count + CW'(1);
                    r_sum   <= r_sum + SUMW'(i_in_data.sample);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.z_init) begin
                r_bit <= QB_W'(Q_BITS - 1);
            end else if (i_cmd.z_cmp) begin
                r_bit <= r_bit - QB_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_d2 <= '0;
        end else if (i_cmd.acc_d2) begin
            r_d2 <= r_d2 + D2W'(r_sq);
        end
        if (i_cmd.calc_d) begin
            r_d <= w_prod - w_sum_s;
        end
        if (i_cmd.calc_sq) begin
            r_sq    <= w_dmag * w_dmag;
            r_dneg  <= r_d[DW-1];
            r_dzero <= (r_d == '0);
        end
        if (i_cmd.calc_r) begin
            r_r <= (RW'(r_sq) * RW'(r_count)) << (2 * FRAC_BITS + 2);
        end
        if (i_cmd.z_init) begin
            r_a <= w_d2x;
            r_b <= -$signed({1'b0, w_d2x});
            r_q <= '0;
        end
        if (i_cmd.z_cand) begin
            r_cand <= $signed({1'b0, r_a}) + (r_b <<< (r_bit + 2))
                    + $signed({1'b0, w_d2x << (2 * r_bit + 2)});
        end
        if (i_cmd.z_cmp && (r_cand <= w_rx)) begin
            r_a        <= r_cand[XW-1:0];
            r_q[r_bit] <= 1'b1;
            r_b        <= r_b + $signed({1'b0, w_d2x << (r_bit + 1)});
        end
        if (i_cmd.z_fin) begin
            if ((r_d2 == '0) || r_dzero) begin
                r_out.normalized <= '0;
            end else begin
                r_out.normalized <= r_dneg ? -$signed(w_mag) : $signed(w_mag);
            end
            r_out.last_out <= o_stat.last_elem;
            r_out.dropped  <= r_ovf;
        end
    end

    assign o_stat.last_elem = (r_idx == r_count - CW'(1));
    assign o_stat.bit_done  = (r_bit == '0);
    assign o_out_data       = r_out;

endmodule

/* sv/zvn_checker.sv */
// ----------------------------------------------------------------------------
// zvn_checker
// Port-level checks for the z-score vector normalizer.
// ----------------------------------------------------------------------------
module zvn_checker
    import zvn_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    a_no_load_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while result pending");

    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.is_last) |=> !o_in_ready)
        else $error("input taken right after vector end");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");

endmodule

bind zscore_vector_normalizer zvn_checker u_zvn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives Q8.8 vectors into the z-score normalizer and checks every result
// against an exact integer prediction of (sample - mean) / stddev in Q5.10.
// ----------------------------------------------------------------------------
module testbench;
    import zvn_pkg::*;

    localparam int DEPTH = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    zscore_vector_normalizer #(.MAX_SAMPLES(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    t_in_item  pending_q[$];
    t_out_item zscore_q[$];

    longint vec_buf[DEPTH];
    int     vec_count;
    longint vec_sum;
    bit     vec_overflow;

    int     error_count;
    int     result_count;
    int     vector_count;
    longint cycle_count;
    bit     quiet_mode;
    int     hold_cycles;
    bit     sender_wait;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(input string msg);
        $display("MISMATCH @%0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Rounded magnitude of 1024*|d|*sqrt(n/d2) by exact bitwise search.
    function automatic int unsigned z_magnitude(longint unsigned dmag,
                                                longint unsigned n,
                                                longint unsigned d2);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned odd;
        int unsigned q;
        int unsigned t;
        q = 0;
        rhs = 128'(dmag * dmag) * 128'(n << 22);
        for (int b = Q_BITS - 1; b >= 0; b--) begin
            t = q | (1 << b);
            odd = 2 * longint'(t) - 1;
            lhs = 128'(odd * odd) * 128'(d2);
            if (lhs <= rhs) q = t;
        end
        return q;
    endfunction

    task automatic predict_sample(input t_in_item item);
        longint d;
        longint unsigned d2;
        longint unsigned m;
        longint v;
        t_out_item r;
        if (vec_count < DEPTH) begin
            vec_buf[vec_count] = longint'(item.sample);
            vec_count++;
            vec_sum += longint'(item.sample);
        end else begin
            vec_overflow = 1'b1;
        end
        if (!item.is_last) return;
        d2 = 0;
        for (int i = 0; i < vec_count; i++) begin
            d = vec_count * vec_buf[i] - vec_sum;
            m = d < 0 ? -d : d;
            d2 += m * m;
        end
        for (int i = 0; i < vec_count; i++) begin
            d = vec_count * vec_buf[i] - vec_sum;
            v = 0;
            if (d2 != 0 && d != 0) begin
                v = z_magnitude(d < 0 ? -d : d, vec_count, d2);
                if (d < 0) v = -v;
            end
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            r.normalized = v[15:0];
            r.last_out = (i + 1 == vec_count);
            r.dropped = vec_overflow;
            zscore_q.push_back(r);
        end
        vector_count++;
        vec_count = 0;
        vec_sum = 0;
        vec_overflow = 1'b0;
    endtask

    task automatic add_sample(input logic signed [15:0] s, input bit last);
        t_in_item item;
        item.sample = s;
        item.is_last = last;
        pending_q.push_back(item);
    endtask

    function automatic logic signed [15:0] rand_sample(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 64)) - 16'sd32;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 2047)) - 16'sd1024;
        endcase
    endfunction

    // driver
    int send_gap;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
            send_gap   <= 0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid && o_in_ready) predict_sample(i_in_data);
            if (send_gap > 0) begin
                send_gap   <= send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0 && !(sender_wait && zscore_q.size() > 0)
                         && !(i_in_valid && o_in_ready && i_in_data.is_last
                              && sender_wait)) begin
                if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                    send_gap   <= $urandom_range(1, 8);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data  <= pending_q.pop_front();
                    i_in_valid <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver stall and monitor
    int recv_gap;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap    <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                result_count++;
                if (zscore_q.size() == 0) begin
                    report($sformatf("unexpected result %p", o_out_data));
                end else begin
                    t_out_item e;
                    e = zscore_q.pop_front();
                    if (o_out_data.normalized !== e.normalized)
                        report($sformatf("normalized %0d, want %0d",
                                         o_out_data.normalized, e.normalized));
                    if (o_out_data.last_out !== e.last_out)
                        report($sformatf("last_out %b, want %b",
                                         o_out_data.last_out, e.last_out));
                    if (o_out_data.dropped !== e.dropped)
                        report($sformatf("dropped %b, want %b",
                                         o_out_data.dropped, e.dropped));
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap    <= recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                recv_gap    <= $urandom_range(1, 8);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        int n;
        int mode;
        int total;
        i_rst_n      = 1'b0;
        error_count  = 0;
        result_count = 0;
        vector_count = 0;
        cycle_count  = 0;
        quiet_mode   = 1'b0;
        hold_cycles  = 0;
        sender_wait  = 1'b0;
        vec_count    = 0;
        vec_sum      = 0;
        vec_overflow = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: single sample, extremes, zero spread, pair
        add_sample(16'sh1234, 1'b1);
        add_sample(16'sh7fff, 1'b0);
        add_sample(16'sh8000, 1'b1);
        add_sample(16'sh0100, 1'b0);
        add_sample(16'sh0100, 1'b0);
        add_sample(16'sh0100, 1'b1);
        add_sample(16'sh8000, 1'b0);
        add_sample(16'sh8000, 1'b0);
        add_sample(16'sh7fff, 1'b1);
        add_sample(16'sh0000, 1'b0);
        add_sample(16'shffff, 1'b0);
        add_sample(16'sh5555, 1'b0);
        add_sample(16'shaaaa, 1'b1);
        total = 13;

        // full buffer, then overflow with last on a dropped sample
        for (int i = 0; i < DEPTH + 3; i++)
            add_sample(rand_sample(0), i == DEPTH + 2);
        total += DEPTH + 3;

        // long receiver hold so the block fills and stalls its input
        hold_cycles = 3000;
        while (pending_q.size() > 0 || zscore_q.size() > 0) @(posedge i_clk);

        // sender pauses until every result has come
        sender_wait = 1'b1;
        for (int i = 0; i < 5; i++) add_sample(rand_sample(3), i == 4);
        for (int i = 0; i < 4; i++) add_sample(rand_sample(1), i == 3);
        while (pending_q.size() > 0 || zscore_q.size() > 0) @(posedge i_clk);
        sender_wait = 1'b0;
        total += 9;

        while (total < 410) begin
            mode = $urandom_range(0, 3);
            if ($urandom_range(0, 15) == 0) n = $urandom_range(DEPTH - 2, DEPTH + 4);
            else n = $urandom_range(1, 12);
            for (int i = 0; i < n; i++) add_sample(rand_sample(mode), i == n - 1);
            total += n;
        end
        while (pending_q.size() > 70) @(posedge i_clk);
        quiet_mode = 1'b1;
        while (pending_q.size() > 0 || i_in_valid) @(posedge i_clk);
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("DONE: errors detected");
                $finish;
            end
            if (quiet_mode && pending_q.size() == 0 && !i_in_valid
                && zscore_q.size() == 0 && vec_count == 0) begin
                repeat (200) @(posedge i_clk);
                $display("covered %0d vectors, %0d results checked",
                         vector_count, result_count);
                if (error_count == 0 && zscore_q.size() == 0) begin
                    $display("DONE: 0 errors");
                end else begin
                    $display("DONE: errors detected");
                end
                $finish;
            end
        end
    end

endmodule
